FILE: hw/rtl/ued_pkg.sv
// ----------------------------------------------------------------------------
// ued_pkg
// Shared types and constants for the ultrasonic echo distance capture block.
// ----------------------------------------------------------------------------
package ued_pkg;

  // event kinds on the input channel
  localparam logic [1:0] KIND_CAPTURE  = 2'd0;
  localparam logic [1:0] KIND_OVERFLOW = 2'd1;
  localparam logic [1:0] KIND_MEASURE  = 2'd2;

  localparam int unsigned OVF_W   = 6;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned SCALE_W = 10;
  localparam int unsigned DIST_W  = 20;
  localparam int unsigned PROD_W  = 32;

  localparam logic [OVF_W-1:0]   OVF_MAX      = 6'h3F;
  localparam logic [TICK_W-1:0]  TICKS_SAT    = 16'hFFFF;
  localparam logic [SCALE_W-1:0] SCALE_RESET  = 10'd170;
  localparam logic [DIST_W-1:0]  DIST_MAX     = 20'hFFFFF;

  // product at or above this gives a distance past the 20-bit range
  localparam logic [PROD_W-1:0]  PROD_SAT     = 32'd1048576000;

  // floor(2^32 / 125), used on the product shifted down by three
  localparam logic [25:0]        RECIP_125    = 26'd34359738;
  localparam logic [27:0]        DIV_125      = 28'd125;

  typedef struct packed {
    logic updated;
    logic trig;
    logic crst;
    logic exp_edge;
  } flags_t;

endpackage

FILE: hw/rtl/ued_ctrl.sv
// ----------------------------------------------------------------------------
// ued_ctrl
// Capture state tracking and the time-by-scale product for one event word.
// ----------------------------------------------------------------------------
module ued_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_v,
  input  logic [1:0]                      kind,
  input  logic [ued_pkg::TICK_W-1:0]      cap,
  input  logic [ued_pkg::SCALE_W-1:0]     scale,
  output logic                            v_r,
  output logic [ued_pkg::PROD_W-1:0]      prod_r,
  output ued_pkg::flags_t                 flags_r
);

  logic                          pulse_done_r, pulse_done_nxt;
  logic                          high_seen_r, high_seen_nxt;
  logic [ued_pkg::OVF_W-1:0]     ovf_r, ovf_nxt;
  logic [ued_pkg::TICK_W-1:0]    ticks_r, ticks_nxt;
  ued_pkg::flags_t               flags_nxt;
  logic [ued_pkg::PROD_W-1:0]    prod_nxt;
  logic [ued_pkg::OVF_W+ued_pkg::TICK_W-1:0] ticks_total;

  always_comb begin
    pulse_done_nxt = pulse_done_r;
    high_seen_nxt  = high_seen_r;
    ovf_nxt        = ovf_r;
    ticks_nxt      = ticks_r;
    flags_nxt      = '0;
    unique case (kind)
      ued_pkg::KIND_CAPTURE: begin
        if (!pulse_done_r) begin
          if (high_seen_r) begin
            pulse_done_nxt = 1'b1;
            ticks_nxt      = cap;
          end else begin
            ovf_nxt        = '0;
            ticks_nxt      = '0;
            high_seen_nxt  = 1'b1;
            flags_nxt.crst = 1'b1;
          end
        end
      end
      ued_pkg::KIND_OVERFLOW: begin
        if (!pulse_done_r && high_seen_r) begin
          if (ovf_r == ued_pkg::OVF_MAX) begin
            pulse_done_nxt = 1'b1;
            ticks_nxt      = ued_pkg::TICKS_SAT;
          end else begin
            ovf_nxt = ovf_r + 1'b1;
          end
        end
      end
      ued_pkg::KIND_MEASURE: begin
        flags_nxt.trig = 1'b1;
        if (pulse_done_r) begin
          flags_nxt.updated = 1'b1;
          pulse_done_nxt    = 1'b0;
          high_seen_nxt     = 1'b0;
          ovf_nxt           = '0;
        end
      end
      default: begin
      end
    endcase
    flags_nxt.exp_edge = high_seen_nxt && !pulse_done_nxt;
  end

  // product uses the state before this word, as the distance does
  assign ticks_total = {ovf_r, ticks_r};
  assign prod_nxt    = ued_pkg::PROD_W'(ticks_total) * ued_pkg::PROD_W'(scale);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_done_r <= 1'b0;
      high_seen_r  <= 1'b0;
      ovf_r        <= '0;
      ticks_r      <= '0;
      v_r          <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
      if (in_v) begin
        pulse_done_r <= pulse_done_nxt;
        high_seen_r  <= high_seen_nxt;
        ovf_r        <= ovf_nxt;
        ticks_r      <= ticks_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= prod_nxt;
      flags_r <= flags_nxt;
    end
  end

endmodule

FILE: hw/rtl/ued_conv.sv
// ----------------------------------------------------------------------------
// ued_conv
// Divide-by-1000 of the product and the distance / result register.
// ----------------------------------------------------------------------------
module ued_conv (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_v,
  input  logic [ued_pkg::PROD_W-1:0]    prod,
  input  ued_pkg::flags_t               flags,
  output logic                          v_r,
  output logic [ued_pkg::DIST_W-1:0]    dist_r,
  output ued_pkg::flags_t               flags_r
);

  logic                   v3_r;
  logic [26:0]            q_r;
  logic [20:0]            est_r;
  logic                   sat_r;
  ued_pkg::flags_t        flags3_r;

  logic [26:0]            q;
  logic [52:0]            est_full;
  logic [27:0]            est_ext;
  logic [27:0]            est_x125;
  logic [27:0]            rem;
  logic [20:0]            quot;
  logic [ued_pkg::DIST_W-1:0] dist_nxt;

  // p/1000 == (p>>3)/125; estimate is exact or one low
  assign q        = prod[29:3];
  assign est_full = 53'(q) * 53'(ued_pkg::RECIP_125);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r      <= q;
      est_r    <= est_full[52:32];
      sat_r    <= (prod >= ued_pkg::PROD_SAT);
      flags3_r <= flags;
    end
  end

  // one correction step on the remainder
  assign est_ext  = 28'(est_r);
  assign est_x125 = (est_ext << 7) - (est_ext << 2) + est_ext;
  assign rem      = 28'(q_r) - est_x125;
  assign quot     = est_r + 21'(rem >= ued_pkg::DIV_125);
  assign dist_nxt = sat_r ? ued_pkg::DIST_MAX : quot[ued_pkg::DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r    <= 1'b0;
      dist_r <= '0;
    end else if (en) begin
      v_r <= v3_r;
      if (v3_r && flags3_r.updated) begin
        dist_r <= dist_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flags_r <= flags3_r;
    end
  end

endmodule

FILE: hw/rtl/ultrasonic_echo_distance_capture_top.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_distance_capture_top
// Echo pulse width capture from timer events, with distance conversion.
// ----------------------------------------------------------------------------
//  channel  | handshake          | contents
//  ---------+--------------------+---------------------------------------------
//  in       | in_valid/in_ready  | kind, capture_value
//  out      | out_valid/out_ready| distance, updated, trigger, counter reset,
//           |                    | expected edge
//  cfg      | cfg_wr_en          | speed_scale (10 bits)
//
//  one word per cycle sustained while the output is not stalled; a result passes every stage below in order
//  pipeline: input reg, state + product, reciprocal multiply, result reg
//  the product and the reciprocal multiply each take one stage
//  reset clears the capture state and distance, speed_scale returns to 170
//  while out_valid is high and out_ready low every stage holds and
//  in_ready is low
// ----------------------------------------------------------------------------
module ultrasonic_echo_distance_capture_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_kind,
  input  logic [15:0]                   in_capture_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [19:0]                   out_distance,
  output logic                          out_distance_updated,
  output logic                          out_trigger_pulse,
  output logic                          out_counter_reset,
  output logic                          out_expected_edge,
  input  logic                          cfg_wr_en,
  input  logic [9:0]                    cfg_wr_data
);

  logic                              en;
  logic                              v1_r;
  logic [1:0]                        kind_r;
  logic [ued_pkg::TICK_W-1:0]        cap_r;
  logic [ued_pkg::SCALE_W-1:0]       scale_r;

  logic                              v2;
  logic [ued_pkg::PROD_W-1:0]        prod;
  ued_pkg::flags_t                   flags2;
  ued_pkg::flags_t                   flags_out;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= ued_pkg::SCALE_RESET;
    end else if (cfg_wr_en) begin
      scale_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind_r <= in_kind;
      cap_r  <= in_capture_value;
    end
  end

  ued_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (v1_r),
    .kind    (kind_r),
    .cap     (cap_r),
    .scale   (scale_r),
    .v_r     (v2),
    .prod_r  (prod),
    .flags_r (flags2)
  );

  ued_conv u_conv (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (v2),
    .prod    (prod),
    .flags   (flags2),
    .v_r     (out_valid),
    .dist_r  (out_distance),
    .flags_r (flags_out)
  );

  assign out_distance_updated = flags_out.updated;
  assign out_trigger_pulse    = flags_out.trig;
  assign out_counter_reset    = flags_out.crst;
  assign out_expected_edge    = flags_out.exp_edge;

endmodule

FILE: hw/rtl/ued_checker.sv
// ----------------------------------------------------------------------------
// ued_checker
// Port-level checks on the echo distance capture result channel.
// ----------------------------------------------------------------------------
module ued_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [19:0] out_distance,
  input  logic        out_distance_updated,
  input  logic        out_trigger_pulse,
  input  logic        out_counter_reset,
  input  logic        out_expected_edge
);

  // no result comes out right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a new distance comes only from a measure request, which rearms
  a_update_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_distance_updated |->
      out_trigger_pulse && !out_counter_reset && !out_expected_edge)
    else $error("distance update without trigger or without rearm");

  // the first edge moves the wanted polarity to falling
  a_crst_falling: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_counter_reset |-> out_expected_edge && !out_trigger_pulse)
    else $error("counter reset without falling edge expected");

  // a stalled word holds its distance
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance))
    else $error("stalled result word changed");

endmodule

bind ultrasonic_echo_distance_capture_top ued_checker u_ued_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_distance         (out_distance),
  .out_distance_updated (out_distance_updated),
  .out_trigger_pulse    (out_trigger_pulse),
  .out_counter_reset    (out_counter_reset),
  .out_expected_edge    (out_expected_edge)
);
